>>> rtl/step_to_boundary_ratio_test_core_defines.svh
// assertion macros for the step-to-boundary ratio test core
`ifndef STEP_TO_BOUNDARY_RATIO_TEST_CORE_DEFINES_SVH
`define STEP_TO_BOUNDARY_RATIO_TEST_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define STBR_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define STBR_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define STBR_ASSERT_IMPLY(name, ante, cons, msg)
`define STBR_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

>>> rtl/stbr_pkg.sv
package stbr_pkg;

	// value and step length formats
	localparam int VALUE_WIDTH     = 32;
	localparam int ALPHA_FRAC_BITS = 16;

	// derived widths
	localparam int DIR_W   = VALUE_WIDTH + 1;
	localparam int ALPHA_W = ALPHA_FRAC_BITS + 1;
	localparam int PROD_W  = DIR_W + ALPHA_W + 1;
	localparam int CNT_W   = (ALPHA_FRAC_BITS > 1) ? $clog2(ALPHA_FRAC_BITS) : 1;

	// step length constants
	localparam logic [ALPHA_W-1:0] ALPHA_ONE  = ALPHA_W'(1) << ALPHA_FRAC_BITS;
	localparam logic [ALPHA_W-1:0] ALPHA_ZERO = '0;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CMP,
		ST_DIV,
		ST_WRITE
	} state_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

>>> rtl/stbr_div.sv
`include "step_to_boundary_ratio_test_core_defines.svh"

module stbr_div (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic [stbr_pkg::VALUE_WIDTH-1:0]         num,
	input  logic [stbr_pkg::DIR_W-1:0]               den,
	output stbr_pkg::div_status_t                    status,
	output logic [stbr_pkg::ALPHA_FRAC_BITS-1:0]     quo
);

	logic                                 busy_q;
	logic                                 done_q;
	logic [stbr_pkg::CNT_W-1:0]           cnt_q;
	logic [stbr_pkg::DIR_W-1:0]           rem_q;
	logic [stbr_pkg::DIR_W-1:0]           den_q;
	logic [stbr_pkg::ALPHA_FRAC_BITS-1:0] quo_q;
	logic [stbr_pkg::DIR_W:0]             shifted;
	logic [stbr_pkg::DIR_W:0]             diff;
	logic                                 take;

	// one restoring step: shift remainder, trial subtract
	always_comb begin
		shifted = {rem_q, 1'b0};
		diff    = shifted - {1'b0, den_q};
		take    = (shifted >= {1'b0, den_q});
	end

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= stbr_pkg::CNT_W'(stbr_pkg::ALPHA_FRAC_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient bits, remainder stays below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? diff[stbr_pkg::DIR_W-1:0] : shifted[stbr_pkg::DIR_W-1:0];
			quo_q <= {quo_q[stbr_pkg::ALPHA_FRAC_BITS-2:0], take};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quo         = quo_q;

	`STBR_ASSERT_NEXT(a_div_start_busy, start, busy_q, "divider did not start")
	`STBR_ASSERT_IMPLY(a_div_done_idle, done_q, !busy_q, "divider done while busy")
	`STBR_ASSERT_IMPLY(a_div_rem_bound, busy_q, rem_q < den_q, "remainder not below divisor")

endmodule

>>> rtl/step_to_boundary_ratio_test_core.sv
// Ratio test for the maximum step to the boundary of an interior-point iterate.
// Each request carries one component (primal or dual group, current value c,
// predictor p and corrector q, all signed Q16.16); the step d = p + q is formed
// exactly and, when d > c and alpha*d > c, the group's running step length
// becomes |c|/|d| truncated and saturated to [0, 1] in Q1.16 (65536 is 1.0).
// The request marked last produces one result with both step lengths, after
// which both restart at 1.0. One component is worked at a time: a request
// passes the MUL, CMP and WRITE states, and also DIV when a quotient is
// needed, where it waits on the 16-step radix-2 restoring divider; a last
// request also waits in WRITE until the output register is free. item_stall
// is high while a request is in work.
`include "step_to_boundary_ratio_test_core_defines.svh"

module step_to_boundary_ratio_test_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic                                   kind,
	input  logic signed [stbr_pkg::VALUE_WIDTH-1:0] current_value,
	input  logic signed [stbr_pkg::VALUE_WIDTH-1:0] predictor_direction,
	input  logic signed [stbr_pkg::VALUE_WIDTH-1:0] corrector_direction,
	input  logic                                   last_item,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic [stbr_pkg::ALPHA_W-1:0]           alpha_primal,
	output logic [stbr_pkg::ALPHA_W-1:0]           alpha_dual
);

	localparam int VW   = stbr_pkg::VALUE_WIDTH;
	localparam int DW   = stbr_pkg::DIR_W;
	localparam int AW   = stbr_pkg::ALPHA_W;
	localparam int PW   = stbr_pkg::PROD_W;
	localparam int FB   = stbr_pkg::ALPHA_FRAC_BITS;

	stbr_pkg::state_t      state_q, state_d;
	stbr_pkg::div_status_t div_st;

	logic [AW-1:0]        primal_step_q, dual_step_q;
	logic [AW-1:0]        alpha_q, new_alpha_q, cmp_alpha;
	logic                 kind_q, last_q;
	logic signed [VW-1:0] cur_q;
	logic signed [DW-1:0] dir_q;
	logic signed [PW-1:0] prod_q;
	logic [VW-1:0]        mag_c_q;
	logic [DW-1:0]        mag_d_q;
	logic                 gt_q, ge_q;
	logic signed [PW-1:0] product, cur_sh;
	logic signed [DW-1:0] dir_sum, cur_ext;
	logic [FB-1:0]        div_quo;
	logic                 accept, hit, need_div, div_start, out_free;
	logic                 result_valid_q;
	logic [AW-1:0]        alpha_primal_q, alpha_dual_q;

	// request handshake and output slot
	assign accept   = item_valid && !item_stall;
	assign out_free = !result_valid_q || !result_stall;

	// full step and shared multiply
	assign dir_sum = {predictor_direction[VW-1], predictor_direction}
		+ {corrector_direction[VW-1], corrector_direction};
	assign cur_ext = {cur_q[VW-1], cur_q};
	assign product = $signed({1'b0, alpha_q}) * dir_q;
	assign cur_sh  = {{(PW-VW-FB){cur_q[VW-1]}}, cur_q, {FB{1'b0}}};

	// ratio test decision
	always_comb begin
		hit       = gt_q && (prod_q > cur_sh);
		need_div  = 1'b0;
		cmp_alpha = alpha_q;
		if (hit) begin
			if (cur_q == '0) begin
				cmp_alpha = stbr_pkg::ALPHA_ZERO;
			end else if (cur_q[VW-1] && !dir_q[DW-1]) begin
				cmp_alpha = stbr_pkg::ALPHA_ZERO;
			end else if (ge_q) begin
				cmp_alpha = stbr_pkg::ALPHA_ONE;
			end else begin
				need_div = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			stbr_pkg::ST_IDLE:  if (accept) state_d = stbr_pkg::ST_MUL;
			stbr_pkg::ST_MUL:   state_d = stbr_pkg::ST_CMP;
			stbr_pkg::ST_CMP:   state_d = need_div ? stbr_pkg::ST_DIV : stbr_pkg::ST_WRITE;
			stbr_pkg::ST_DIV:   if (div_st.done) state_d = stbr_pkg::ST_WRITE;
			stbr_pkg::ST_WRITE: if (!last_q || out_free) state_d = stbr_pkg::ST_IDLE;
			default:            state_d = stbr_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_stall = 1'b1;
		div_start  = 1'b0;
		case (state_q)
			stbr_pkg::ST_IDLE: item_stall = 1'b0;
			stbr_pkg::ST_CMP:  div_start  = need_div;
			default: begin
				item_stall = 1'b1;
				div_start  = 1'b0;
			end
		endcase
	end

	// state, step lengths and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= stbr_pkg::ST_IDLE;
			primal_step_q  <= stbr_pkg::ALPHA_ONE;
			dual_step_q    <= stbr_pkg::ALPHA_ONE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (state_q == stbr_pkg::ST_WRITE) begin
				if (last_q) begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						primal_step_q  <= stbr_pkg::ALPHA_ONE;
						dual_step_q    <= stbr_pkg::ALPHA_ONE;
					end
				end else if (kind_q) begin
					dual_step_q <= new_alpha_q;
				end else begin
					primal_step_q <= new_alpha_q;
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == stbr_pkg::ST_WRITE && last_q && out_free) begin
			alpha_primal_q <= kind_q ? primal_step_q : new_alpha_q;
			alpha_dual_q   <= kind_q ? new_alpha_q : dual_step_q;
		end
	end

	// request capture and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind;
			last_q  <= last_item;
			cur_q   <= current_value;
			dir_q   <= dir_sum;
			alpha_q <= kind ? dual_step_q : primal_step_q;
		end
		if (state_q == stbr_pkg::ST_MUL) begin
			prod_q  <= product;
			gt_q    <= dir_q > cur_ext;
			mag_c_q <= cur_q[VW-1] ? VW'(-cur_q) : VW'(cur_q);
			mag_d_q <= dir_q[DW-1] ? DW'(-dir_q) : DW'(dir_q);
		end
		if (state_q == stbr_pkg::ST_CMP) begin
			ge_q <= 1'b0;
		end else if (state_q == stbr_pkg::ST_MUL) begin
			ge_q <= (cur_q[VW-1] ? {1'b0, VW'(-cur_q)} : {1'b0, VW'(cur_q)})
				>= (dir_q[DW-1] ? DW'(-dir_q) : DW'(dir_q));
		end
		if (state_q == stbr_pkg::ST_CMP && !need_div) begin
			new_alpha_q <= cmp_alpha;
		end else if (state_q == stbr_pkg::ST_DIV && div_st.done) begin
			new_alpha_q <= {1'b0, div_quo};
		end
	end

	// iterative divider for |c| * 2^16 / |d|
	stbr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mag_c_q),
		.den    (mag_d_q),
		.status (div_st),
		.quo    (div_quo)
	);

	assign result_valid = result_valid_q;
	assign alpha_primal = alpha_primal_q;
	assign alpha_dual   = alpha_dual_q;

	`STBR_ASSERT_IMPLY(a_step_range, 1'b1, (primal_step_q <= stbr_pkg::ALPHA_ONE) && (dual_step_q <= stbr_pkg::ALPHA_ONE), "step length above one")
	`STBR_ASSERT_NEXT(a_div_to_write, (state_q == stbr_pkg::ST_DIV) && div_st.done, state_q == stbr_pkg::ST_WRITE, "quotient not written")
	`STBR_ASSERT_NEXT(a_last_restart, (state_q == stbr_pkg::ST_WRITE) && last_q && out_free, result_valid_q && (primal_step_q == stbr_pkg::ALPHA_ONE) && (dual_step_q == stbr_pkg::ALPHA_ONE), "pass end did not restart steps")
	`STBR_ASSERT_IMPLY(a_div_only_in_div, div_st.busy, state_q == stbr_pkg::ST_DIV, "divider busy outside divide state")

endmodule
